>>> rtl/core/lcpist_pkg.sv
// Shared types for the LCP interval stack traversal core.
// Holds the event codes and the command and status bundles between
// the controller and the datapath. Depends on nothing.
package lcpist_pkg;

	typedef enum logic [1:0] {
		EV_CLOSE   = 2'd0,
		EV_SIBLING = 2'd1,
		EV_OPEN    = 2'd2,
		EV_ERROR   = 2'd3
	} ev_kind_t;

	// Commands from the controller, at most one active per cycle.
	typedef struct packed {
		logic load;      // take the input item into the working registers
		logic pop_read;  // read the frame below the top from the stack memory
		logic pop_close; // emit a close event and drop the top frame
		logic sibling;   // emit a sibling edge event
		logic open;      // emit an open event and push a frame
		logic error;     // emit an error event and set the sticky error
	} cmd_t;

	typedef struct packed {
		logic pop_needed; // more than one frame and the LCP is below the top depth
		logic eq_top;     // the LCP equals the top depth
		logic full;       // every frame slot is taken
		logic sticky;     // an overflow has happened since reset
		logic out_free;   // the output register can take a result this cycle
	} stat_t;

endpackage

>>> rtl/core/lcp_interval_stack_traversal_core.sv
// Channel  Handshake            Payload
// in       in_valid/in_stall    lcp_value, suffix_pos
// out      out_valid/out_stall  event_kind, edge_is_leaf, first_edge, node_depth,
//                               frame_level, parent_depth, item_index,
//                               suffix_echo, lcp_echo, last
//
// An item runs through these steps with a free output: accept, then for each
// frame it closes a stack memory read followed by the close event, then the
// decision that emits the final event.
// The stack memory read is registered, so each close event waits for the registered frame below.
// Reset arst_n is asynchronous; after it the root frame alone is open.
// A stalled output holds the block at its next event; a stack memory read and,
// while idle, one item are still taken, and then wait until the output register is free.
module lcp_interval_stack_traversal_core #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] lcp_value,
	input  logic [31:0] suffix_pos,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic        edge_is_leaf,
	output logic        first_edge,
	output logic [31:0] node_depth,
	output logic [4:0]  frame_level,
	output logic [31:0] parent_depth,
	output logic [31:0] item_index,
	output logic [31:0] suffix_echo,
	output logic [31:0] lcp_echo,
	output logic        last
);
	import lcpist_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lcpist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	lcpist_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.lcp_value    (lcp_value),
		.suffix_pos   (suffix_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.edge_is_leaf (edge_is_leaf),
		.first_edge   (first_edge),
		.node_depth   (node_depth),
		.frame_level  (frame_level),
		.parent_depth (parent_depth),
		.item_index   (item_index),
		.suffix_echo  (suffix_echo),
		.lcp_echo     (lcp_echo),
		.last         (last)
	);

endmodule

>>> rtl/core/lcpist_ctrl.sv
// Controller of the LCP interval stack traversal core.
// Sequences accept, pop and final event steps; uses lcpist_pkg.
module lcpist_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lcpist_pkg::stat_t stat,
	output lcpist_pkg::cmd_t  cmd
);
	import lcpist_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_POP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.sticky) begin
					if (stat.out_free) begin
						cmd.error = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (stat.pop_needed) begin
					cmd.pop_read = 1'b1;
					state_d      = ST_POP;
				end else if (stat.out_free) begin
					if (stat.eq_top) begin
						cmd.sibling = 1'b1;
					end else if (stat.full) begin
						cmd.error = 1'b1;
					end else begin
						cmd.open = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				if (stat.out_free) begin
					cmd.pop_close = 1'b1;
					state_d       = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/lcpist_dp.sv
// Datapath of the LCP interval stack traversal core.
// Holds the cached top frame, the stack memory, counters and the output
// register; driven by commands from lcpist_ctrl; uses lcpist_pkg.
module lcpist_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcpist_pkg::cmd_t cmd,
	output lcpist_pkg::stat_t stat,
	input  logic [31:0]      lcp_value,
	input  logic [31:0]      suffix_pos,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       event_kind,
	output logic             edge_is_leaf,
	output logic             first_edge,
	output logic [31:0]      node_depth,
	output logic [4:0]       frame_level,
	output logic [31:0]      parent_depth,
	output logic [31:0]      item_index,
	output logic [31:0]      suffix_echo,
	output logic [31:0]      lcp_echo,
	output logic             last
);
	import lcpist_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// The top frame lives in registers; the memory holds the frames below it,
	// so levels 0 to STACK_DEPTH-2 at most.
	logic [32:0] mem [0:STACK_DEPTH-2];

	logic [31:0]   lcp_q;
	logic [31:0]   suf_q;
	logic [31:0]   index_q;
	logic [31:0]   top_depth_q;
	logic          top_flag_q;
	logic [CW-1:0] count_q;
	logic          root_pend_q;
	logic          sticky_q;
	logic [31:0]   rd_depth_q;
	logic          rd_flag_q;

	logic          out_valid_q;
	ev_kind_t      kind_q;
	logic          leaf_q;
	logic          first_q;
	logic [31:0]   depth_q;
	logic [4:0]    level_q;
	logic [31:0]   parent_q;
	logic [31:0]   index_out_q;
	logic [31:0]   suf_out_q;
	logic [31:0]   lcp_out_q;
	logic          last_q;

	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [31:0]   top_lvl32;
	logic [31:0]   new_lvl32;
	logic          emit;
	logic          root_first;

	assign cnt_m1     = count_q - CW'(1);
	assign cnt_m2     = count_q - CW'(2);
	assign top_lvl32  = 32'(cnt_m1);
	assign new_lvl32  = 32'(count_q);
	assign emit       = cmd.pop_close | cmd.sibling | cmd.open | cmd.error;
	assign root_first = root_pend_q && (top_depth_q == 32'd0);

	always_comb begin
		stat.pop_needed = (count_q > CW'(1)) && (lcp_q < top_depth_q);
		stat.eq_top     = (lcp_q == top_depth_q);
		stat.full       = (count_q >= CW'(STACK_DEPTH));
		stat.sticky     = sticky_q;
		stat.out_free   = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.open) begin
			// The enclosing frame's last edge is a branch edge from now on.
			mem[cnt_m1[AW-1:0]] <= {top_depth_q, 1'b0};
		end
		if (cmd.pop_read) begin
			{rd_depth_q, rd_flag_q} <= mem[cnt_m2[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lcp_q <= lcp_value;
			suf_q <= suffix_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q     <= '0;
			top_depth_q <= '0;
			top_flag_q  <= 1'b1;
			count_q     <= CW'(1);
			root_pend_q <= 1'b1;
			sticky_q    <= 1'b0;
		end else begin
			if (cmd.error) begin
				sticky_q <= 1'b1;
			end
			if (cmd.pop_close) begin
				top_depth_q <= rd_depth_q;
				top_flag_q  <= rd_flag_q;
				count_q     <= cnt_m1;
			end
			if (cmd.sibling) begin
				top_flag_q <= 1'b1;
				if (root_first) begin
					root_pend_q <= 1'b0;
				end
				index_q <= index_q + 32'd1;
			end
			if (cmd.open) begin
				top_depth_q <= lcp_q;
				top_flag_q  <= 1'b1;
				count_q     <= count_q + CW'(1);
				index_q     <= index_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_out_q <= index_q;
			suf_out_q   <= suf_q;
			lcp_out_q   <= lcp_q;
			if (cmd.pop_close) begin
				kind_q   <= EV_CLOSE;
				leaf_q   <= top_flag_q;
				first_q  <= 1'b0;
				depth_q  <= top_depth_q;
				level_q  <= top_lvl32[4:0];
				parent_q <= rd_depth_q;
				last_q   <= 1'b0;
			end else if (cmd.sibling) begin
				kind_q   <= EV_SIBLING;
				leaf_q   <= top_flag_q;
				first_q  <= root_first;
				depth_q  <= top_depth_q;
				level_q  <= top_lvl32[4:0];
				parent_q <= '0;
				last_q   <= 1'b1;
			end else if (cmd.open) begin
				kind_q   <= EV_OPEN;
				leaf_q   <= top_flag_q;
				first_q  <= 1'b1;
				depth_q  <= lcp_q;
				level_q  <= new_lvl32[4:0];
				parent_q <= '0;
				last_q   <= 1'b1;
			end else begin
				kind_q   <= EV_ERROR;
				leaf_q   <= 1'b0;
				first_q  <= 1'b0;
				depth_q  <= lcp_q;
				level_q  <= '0;
				parent_q <= '0;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign edge_is_leaf = leaf_q;
	assign first_edge   = first_q;
	assign node_depth   = depth_q;
	assign frame_level  = level_q;
	assign parent_depth = parent_q;
	assign item_index   = index_out_q;
	assign suffix_echo  = suf_out_q;
	assign lcp_echo     = lcp_out_q;
	assign last         = last_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(1)) && (count_q <= CW'(STACK_DEPTH)))
		else $error("frame count out of range");
	a_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_read |-> (count_q > CW'(1)) && (lcp_q < top_depth_q) && !sticky_q)
		else $error("pop issued without a frame deeper than the LCP");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.open |-> !stat.full && (lcp_q > top_depth_q))
		else $error("push issued on a full stack or a shallow LCP");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> stat.out_free)
		else $error("result issued while the output register is held");
	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q |=> sticky_q && (index_q == $past(index_q)))
		else $error("state moved after the sticky error");
`endif

endmodule
